FILE: sv/mdq_pkg.sv
// Shared types, codes and constants of the message deque.
`default_nettype none

package mdq_pkg;

  // Default sizing of the store.
  localparam int unsigned DefCapacity = 16;
  localparam int unsigned DefTimeBits = 32;

  // Fixed field widths of the stream items.
  localparam int unsigned HandleW    = 8;
  localparam int unsigned SenderW    = 4;
  localparam int unsigned FieldTimeW = 32;
  localparam int unsigned OccW       = 5;
  localparam int unsigned SendCntW   = 5;
  localparam logic [SendCntW-1:0] SendCntReset = 5'd16;

  // Operation codes carried in the input item.
  typedef enum logic [2:0] {
    OP_PUSH_HEAD = 3'd0,
    OP_PUSH_TAIL = 3'd1,
    OP_POP_HEAD  = 3'd2,
    OP_POP_TAIL  = 3'd3,
    OP_INSERT    = 3'd4,
    OP_REMOVE    = 3'd5
  } op_e;

  // Status codes returned with each result.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  // Rule by which each cell decides whether it is the operating position.
  typedef enum logic [2:0] {
    HIT_NONE   = 3'd0,
    HIT_ALL    = 3'd1,
    HIT_FREE   = 3'd2,
    HIT_LATER  = 3'd3,
    HIT_LAST   = 3'd4,
    HIT_SENDER = 3'd5
  } hit_e;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    hit_e                  rule;
    logic                  open_gap;
    logic                  close_gap;
    logic [HandleW-1:0]    key_handle;
    logic [SenderW-1:0]    key_sender;
    logic [FieldTimeW-1:0] key_time;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/mdq_cell.sv
// One slot of the deque: holds an entry and shifts it to or from its neighbors.
`default_nettype none

module mdq_cell
  import mdq_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5,
  parameter int unsigned TW    = 32,
  localparam int unsigned EntryW = HandleW + SenderW + TW
) (
  input  wire logic              clk_i,
  input  wire cell_ctrl_t        ctrl_i,
  input  wire logic [CNT_W-1:0]  count_i,
  input  wire logic              before_i,  // a cell nearer the head already hit
  input  wire logic [EntryW-1:0] left_i,    // entry of the neighbor toward the head
  input  wire logic [EntryW-1:0] right_i,   // entry of the neighbor toward the tail
  output logic      [EntryW-1:0] entry_o,
  output logic      [EntryW-1:0] next_o,
  output logic                   before_o,
  output logic                   first_o
);

  localparam logic [CNT_W-1:0] IdxC    = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IdxNext = CNT_W'(IDX + 1);

  logic [EntryW-1:0]  entry_q, entry_d;
  logic [EntryW-1:0]  fresh;
  logic               valid;
  logic               hit;
  logic [TW-1:0]      my_time;
  logic [SenderW-1:0] my_sender;

  assign fresh     = {ctrl_i.key_time[TW-1:0], ctrl_i.key_sender, ctrl_i.key_handle};
  assign valid     = (count_i > IdxC);
  assign my_time   = entry_q[EntryW-1 -: TW];
  assign my_sender = entry_q[HandleW +: SenderW];

  // Does this cell qualify as the operating position?
  always_comb begin
    unique case (ctrl_i.rule)
      HIT_ALL:    hit = 1'b1;
      HIT_FREE:   hit = !valid;
      HIT_LATER:  hit = !valid || (my_time > ctrl_i.key_time[TW-1:0]);
      HIT_LAST:   hit = (count_i == IdxNext);
      HIT_SENDER: hit = valid && (my_sender == ctrl_i.key_sender);
      default:    hit = 1'b0;
    endcase
  end

  assign first_o  = hit && !before_i;
  assign before_o = hit || before_i;

  // Open a gap by taking from the left, or close one by taking from the right.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.open_gap) begin
      if (first_o) begin
        entry_d = fresh;
      end else if (before_i) begin
        entry_d = left_i;
      end
    end else if (ctrl_i.close_gap) begin
      if (before_o) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign next_o  = entry_d;

endmodule

`default_nettype wire

FILE: sv/message_deque_with_timed_insert.sv
// Top level of the message deque with timed insert and remove by sender.
`default_nettype none

// The block keeps up to CAPACITY message entries in a row of slot cells, the
// head in cell 0. Every input transfer carries one operation and yields exactly
// one result transfer with the status, the removed entry (zero if none), the
// occupancy and the handles at head and tail after the operation. In each operation
// all cells decide and shift together, and the path that
// sets the clock is the priority chain that runs through the cells to find the
// first entry with a later time or a matching sender. The result sits in an
// output register, so a new operation is taken in the same cycle in which the
// previous result is transferred. Unused operation codes return status ok and
// change nothing. valid_sender_count may only be written while the block is idle.
module message_deque_with_timed_insert
  import mdq_pkg::*;
#(
  parameter int unsigned CAPACITY  = DefCapacity,
  parameter int unsigned TIME_BITS = DefTimeBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // operation[2:0], entry_handle[10:3], entry_sender[14:11], entry_time[46:15]
  input  wire logic [47:0] s_axis_tdata_i,
  // Result items.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // status[1:0], out_handle[9:2], out_sender[13:10], out_time[45:14],
  // occupancy[50:46], front_handle[58:51], back_handle[66:59]
  output logic [71:0]      m_axis_tdata_o,
  // Configuration write of valid_sender_count.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i
);

  localparam int unsigned TW     = (TIME_BITS < FieldTimeW) ? TIME_BITS : FieldTimeW;
  localparam int unsigned CntW   = $clog2(CAPACITY + 1);
  localparam int unsigned EntryW = HandleW + SenderW + TW;
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);
  localparam logic [CntW-1:0] One  = CntW'(1);

  // Input field split.
  logic [2:0]            in_op;
  logic [HandleW-1:0]    in_handle;
  logic [SenderW-1:0]    in_sender;
  logic [FieldTimeW-1:0] in_time;

  assign in_op     = s_axis_tdata_i[2:0];
  assign in_handle = s_axis_tdata_i[10:3];
  assign in_sender = s_axis_tdata_i[14:11];
  assign in_time   = s_axis_tdata_i[46:15];

  logic              s_fire;
  logic              out_valid_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [4:0]        vsc_q;
  cell_ctrl_t        ctrl;
  status_e           status;
  logic              push_op, pull_op, found;
  logic              full, empty;

  logic [EntryW-1:0] cell_entry [CAPACITY];
  logic [EntryW-1:0] cell_next  [CAPACITY];
  logic [CAPACITY:0] hit_chain;
  logic [CAPACITY-1:0] first;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (count_q == CapC);
  assign empty           = (count_q == '0);
  assign found           = hit_chain[CAPACITY];

  // Decode the operation into a cell rule and the status.
  always_comb begin
    ctrl.key_handle = in_handle;
    ctrl.key_sender = in_sender;
    ctrl.key_time   = in_time;
    ctrl.rule       = HIT_NONE;
    push_op         = 1'b0;
    pull_op         = 1'b0;
    status          = ST_OK;
    unique case (in_op) inside
      OP_PUSH_HEAD, OP_PUSH_TAIL, OP_INSERT: begin
        ctrl.rule = (in_op == OP_PUSH_HEAD) ? HIT_ALL :
                    (in_op == OP_PUSH_TAIL) ? HIT_FREE : HIT_LATER;
        if (full) begin
          status = ST_FULL;
        end else begin
          push_op = 1'b1;
        end
      end
      OP_POP_HEAD, OP_POP_TAIL: begin
        ctrl.rule = (in_op == OP_POP_HEAD) ? HIT_ALL : HIT_LAST;
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          pull_op = 1'b1;
        end
      end
      OP_REMOVE: begin
        ctrl.rule = HIT_SENDER;
        if ({1'b0, in_sender} >= vsc_q) begin
          status = ST_INVALID;
        end else if (!found) begin
          status = ST_EMPTY;
        end else begin
          pull_op = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
    ctrl.open_gap  = s_fire && push_op;
    ctrl.close_gap = s_fire && pull_op;
  end

  // The row of slot cells, chained head to tail.
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [EntryW-1:0] left_e, right_e;
    if (i == 0) begin : g_head
      assign left_e = '0;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cell_entry[i+1];
    end
    mdq_cell #(
      .IDX   (i),
      .CNT_W (CntW),
      .TW    (TW)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .count_i  (count_q),
      .before_i (hit_chain[i]),
      .left_i   (left_e),
      .right_i  (right_e),
      .entry_o  (cell_entry[i]),
      .next_o   (cell_next[i]),
      .before_o (hit_chain[i+1]),
      .first_o  (first[i])
    );
  end

  // Next occupancy.
  always_comb begin
    count_d = count_q;
    if (ctrl.open_gap) begin
      count_d = count_q + One;
    end else if (ctrl.close_gap) begin
      count_d = count_q - One;
    end
  end

  // Removed entry and the tail handle after the operation.
  logic [EntryW-1:0]  removed;
  logic [HandleW-1:0] back_handle;
  always_comb begin
    removed     = '0;
    back_handle = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (first[i] && pull_op) begin
        removed = removed | cell_entry[i];
      end
      if (count_d == CntW'(i + 1)) begin
        back_handle = back_handle | cell_next[i][HandleW-1:0];
      end
    end
  end

  logic [HandleW-1:0] front_handle;
  assign front_handle = (count_d == '0) ? '0 : cell_next[0][HandleW-1:0];

  logic [66:0] result;
  assign result = {back_handle,
                   front_handle,
                   OccW'(count_d),
                   FieldTimeW'(removed[EntryW-1 -: TW]),
                   removed[HandleW +: SenderW],
                   removed[HandleW-1:0],
                   status};

  // Occupancy and the output register.
  logic [66:0] result_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (s_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, result_q};

  // Configuration register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsc_q <= SendCntReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vsc_q <= cfg_data_i;
    end
  end

  // The occupancy never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("occupancy above capacity");

  // At most one cell is chosen as the operating position.
  a_first_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first))
    else $error("several cells chosen");

  // A push into a store that is not full grows it by one.
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.open_gap |=> count_q == $past(count_q) + One)
    else $error("push did not grow the store");

  // A successful removal always finds a cell.
  a_pull_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.close_gap |-> found)
    else $error("removal without a chosen cell");

endmodule

`default_nettype wire
